FILE: rtl/core/nft_pkg.sv
// Shared types, constants and codes of the NAT flow table.
// Used by every module of the block but nft_ram; depends on nothing else.
package nft_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;

    // Field widths of the stream items.
    localparam int PROTO_W  = 2;
    localparam int FLOW_W   = 16;
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 12;
    localparam int DIST_W   = 13;
    localparam int HOME_W   = 16;

    // Stream packing.
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 32;
    localparam int SLOT_LSB = 0;
    localparam int DIST_LSB = SLOT_LSB + SLOT_W;
    localparam int ARP_BIT  = DIST_LSB + DIST_W;

    // floor(x / 10000) for 32-bit x equals (x * HASH_MULT) >> HASH_SHIFT.
    localparam logic [31:0] HASH_MULT  = 32'd3518437209;
    localparam int          HASH_SHIFT = 45;

    // The modulo unit retires this many dividend bits per cycle.
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = HOME_W / MOD_BITS;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [PROTO_W-1:0] PROTO_ICMP = 2'd0;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXIST = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_HASH,
        F_MOD,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_CHECK
    } t_back_state;

    typedef struct packed {
        logic [PROTO_W-1:0] proto;
        logic [FLOW_W-1:0]  flow_id;
        logic [IP_W-1:0]    src_ip;
        logic [IP_W-1:0]    dst_ip;
        logic [MAC_W-1:0]   src_mac;
        logic [HOME_W-1:0]  home;
    } t_job;

    typedef struct packed {
        logic               valid;
        logic [IP_W-1:0]    src_ip;
        logic [IP_W-1:0]    dst_ip;
        logic [FLOW_W-1:0]  port;
        logic [MAC_W-1:0]   mac;
        logic [DIST_W-1:0]  distance;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot_index;
        logic [DIST_W-1:0]  probe_distance;
        logic               arp_request;
    } t_result;

endpackage

FILE: rtl/core/nft_ram.sv
// Generic single-port RAM with a registered read.
// Standalone; used for the flow table store.
module nft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/nft_front.sv
// Front end: accepts a flow key and computes its home slot.
// Depends on nft_pkg; feeds nft_queue.
module nft_front #(
    parameter int TABLE_DEPTH = nft_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_hold,
    input  logic          i_valid,
    output logic          o_ready,
    input  nft_pkg::t_job i_job,
    output logic          o_push,
    output nft_pkg::t_job o_job,
    input  logic          i_full
);
    import nft_pkg::*;

    localparam int RW = $clog2(TABLE_DEPTH) + 1;
    localparam logic [RW-1:0] DEPTH_R = RW'(TABLE_DEPTH);
    localparam int CW = $clog2(MOD_STEPS);

    t_front_state r_state, n_state;
    t_job         r_job, n_job;
    logic [63:0]  r_prod, n_prod;
    logic [HOME_W-1:0] r_dvd, n_dvd;
    logic [RW-1:0]     r_rem, n_rem;
    logic [CW-1:0]     r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_prod <= n_prod;
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
    end

    always_comb begin
        logic [HOME_W-1:0] sum;
        logic [RW-1:0]     tmp;
        n_state = r_state;
        n_job   = r_job;
        n_prod  = r_prod;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        o_ready = (r_state == F_IDLE) && !i_hold;
        o_push  = 1'b0;
        sum     = '0;
        tmp     = r_rem;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid && o_ready) begin
                    n_job   = i_job;
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_prod  = {32'd0, r_job.src_ip} * {32'd0, HASH_MULT};
                n_state = F_HASH;
            end
            F_HASH: begin
                sum     = r_job.flow_id + r_prod[HASH_SHIFT +: HOME_W];
                n_dvd   = {sum[7:0], sum[15:8]};
                n_rem   = '0;
                n_cnt   = '0;
                n_state = F_MOD;
            end
            F_MOD: begin
                // Restoring reduction modulo the table depth, a few bits a cycle.
                for (int k = 0; k < MOD_BITS; k++) begin
                    tmp = {tmp[RW-2:0], r_dvd[HOME_W-1-k]};
                    if (tmp >= DEPTH_R) begin
                        tmp = tmp - DEPTH_R;
                    end
                end
                n_rem = tmp;
                n_dvd = r_dvd << MOD_BITS;
                n_cnt = CW'(r_cnt + 1'b1);
                if (r_cnt == CW'(MOD_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_job      = r_job;
        o_job.home = HOME_W'(r_rem);
    end
endmodule

FILE: rtl/core/nft_queue.sv
// Short job queue between the hash front end and the probe back end.
// Depends on nft_pkg.
module nft_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nft_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output nft_pkg::t_job o_job,
    input  logic          i_pop
);
    import nft_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= NW'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= NW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_full  = (r_count == NW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
endmodule

FILE: rtl/core/nft_back.sv
// Back end: clears the table after reset, probes it one slot per cycle,
// inserts new rules and holds the result register. Depends on nft_pkg, nft_ram.
module nft_back #(
    parameter int TABLE_DEPTH = nft_pkg::TABLE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    output logic             o_clearing,
    input  logic             i_q_valid,
    input  nft_pkg::t_job    i_q_job,
    output logic             o_q_pop,
    output logic             o_valid,
    output nft_pkg::t_result o_result,
    input  logic             i_ready
);
    import nft_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
    localparam int EW = $bits(t_entry);

    t_back_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW-1:0] r_slot, n_slot;
    logic [AW-1:0] r_dist, n_dist;
    t_job          r_job, n_job;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    t_entry        ram_wdata;
    logic [EW-1:0] ram_rdata;
    t_entry        entry;
    logic          hit, out_free;

    nft_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_dist <= n_dist;
        r_job  <= n_job;
        r_out  <= n_out;
    end

    assign entry    = t_entry'(ram_rdata);
    assign hit      = entry.valid && (entry.src_ip == r_job.src_ip)
                      && (entry.dst_ip == r_job.dst_ip);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_slot      = r_slot;
        n_dist      = r_dist;
        n_job       = r_job;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = r_slot;
        ram_wdata   = '0;
        o_q_pop     = 1'b0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            B_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                n_clr    = AW'(r_clr + 1'b1);
                if (r_clr == LAST) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_job    = i_q_job;
                    n_slot   = AW'(i_q_job.home);
                    n_dist   = '0;
                    ram_re   = 1'b1;
                    ram_addr = AW'(i_q_job.home);
                    n_state  = B_CHECK;
                end
            end
            B_CHECK: begin
                // A conclusion waits here, read data held, until the result
                // register is free.
                if (hit) begin
                    if (out_free) begin
                        n_out_valid          = 1'b1;
                        n_out.status         = ST_EXIST;
                        n_out.slot_index     = SLOT_W'(r_slot);
                        n_out.probe_distance = DIST_W'(r_dist);
                        n_out.arp_request    = 1'b0;
                        n_state              = B_IDLE;
                    end
                end else if (!entry.valid) begin
                    if (out_free) begin
                        ram_we               = 1'b1;
                        ram_wdata.valid      = 1'b1;
                        ram_wdata.src_ip     = r_job.src_ip;
                        ram_wdata.dst_ip     = r_job.dst_ip;
                        ram_wdata.port       = r_job.flow_id;
                        ram_wdata.mac        = r_job.src_mac;
                        ram_wdata.distance   = DIST_W'(r_dist);
                        n_out_valid          = 1'b1;
                        n_out.status         = ST_NEW;
                        n_out.slot_index     = SLOT_W'(r_slot);
                        n_out.probe_distance = DIST_W'(r_dist);
                        n_out.arp_request    = (r_job.proto == PROTO_ICMP)
                                               || (r_job.proto == PROTO_UDP);
                        n_state              = B_IDLE;
                    end
                end else if (r_dist == LAST) begin
                    if (out_free) begin
                        n_out_valid          = 1'b1;
                        n_out.status         = ST_FULL;
                        n_out.slot_index     = SLOT_W'(r_job.home);
                        n_out.probe_distance = DIST_W'(TABLE_DEPTH);
                        n_out.arp_request    = 1'b0;
                        n_state              = B_IDLE;
                    end
                end else begin
                    n_slot   = (r_slot == LAST) ? '0 : AW'(r_slot + 1'b1);
                    n_dist   = AW'(r_dist + 1'b1);
                    ram_re   = 1'b1;
                    ram_addr = n_slot;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_clearing = (r_state == B_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;
endmodule

FILE: rtl/core/nat_flow_table_linear_probe.sv
// NAT flow table with linear probing: how to use the block.
// Slave stream: one flow key per transfer; s_tuser carries the protocol code
// and s_tdata the flow id, source address, destination address and source MAC.
// Master stream: one result per key; m_tuser carries the status (rule existed,
// new rule inserted, table full) and m_tdata the slot, probe distance and
// ARP request flag.
// After reset the table store is cleared one slot per cycle; s_tready stays low
// during that pass. The hash front end takes a new key only after it has pushed
// the last one into the queue; it works through a 32x32 reciprocal multiply,
// the byte swap, and a modulo unit that retires 4 bits a cycle.
// The probe back end reads one table slot per cycle from a single-port RAM.
// A two-entry queue lets the front end keep accepting keys while the back end
// probes or waits on a stalled result.
// A result that is not taken stays in the output register; the back end then
// holds its probe, and the queue and the front end fill up and drop s_tready.
// Depends on nft_pkg, nft_front, nft_queue, nft_back and nft_ram.
module nat_flow_table_linear_probe #(
    parameter int TABLE_DEPTH = nft_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // flow_id[15:0], src_ip[47:16], dst_ip[79:48], src_mac[127:80]
    input  logic [nft_pkg::S_DATA_W-1:0]   s_tdata,
    // proto[1:0]
    input  logic [nft_pkg::PROTO_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot_index[11:0], probe_distance[24:12], arp_request[25], zero[31:26]
    output logic [nft_pkg::M_DATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [nft_pkg::STATUS_W-1:0]   m_tuser
);
    import nft_pkg::*;

    t_job    in_job, push_job, q_job;
    t_result result;
    logic    clearing, push, q_full, q_valid, q_pop;

    always_comb begin
        in_job.proto   = s_tuser;
        in_job.flow_id = s_tdata[FLOW_W-1:0];
        in_job.src_ip  = s_tdata[FLOW_W +: IP_W];
        in_job.dst_ip  = s_tdata[FLOW_W + IP_W +: IP_W];
        in_job.src_mac = s_tdata[FLOW_W + 2*IP_W +: MAC_W];
        in_job.home    = '0;
    end

    nft_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (clearing),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_job   (in_job),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (q_full)
    );

    nft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    nft_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (clearing),
        .i_q_valid  (q_valid),
        .i_q_job    (q_job),
        .o_q_pop    (q_pop),
        .o_valid    (m_tvalid),
        .o_result   (result),
        .i_ready    (m_tready)
    );

    always_comb begin
        m_tdata = '0;
        m_tdata[SLOT_LSB +: SLOT_W] = result.slot_index;
        m_tdata[DIST_LSB +: DIST_W] = result.probe_distance;
        m_tdata[ARP_BIT]            = result.arp_request;
        m_tuser                     = result.status;
    end
endmodule

FILE: rtl/core/nft_checker.sv
// Port-level checks of the NAT flow table, bound to its top level.
// Depends on nft_pkg and nat_flow_table_linear_probe.
module nft_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [nft_pkg::M_DATA_W-1:0] m_tdata,
    input logic [nft_pkg::STATUS_W-1:0] m_tuser
);
    import nft_pkg::*;

    // Reset starts the clearing pass: no key taken, no result shown.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_tready && !m_tvalid)
        else $error("input ready or result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    // Only a newly inserted rule may ask for ARP resolution.
    a_arp_new_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != ST_NEW) |-> !m_tdata[ARP_BIT])
        else $error("ARP request on a result that is not a new rule");
endmodule

bind nat_flow_table_linear_probe nft_checker u_nft_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the NAT flow table with linear probing.
// Depends on nft_pkg and nat_flow_table_linear_probe; a scoreboard class tracks the
// rule table and checks each result transfer against its own prediction.
module testbench;
    import nft_pkg::*;

    localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
    localparam int HASH_DIVISOR = 10000;
    localparam int RANDOM_ITEMS = 1636;
    localparam int MAX_GAP      = 18;
    localparam int END_SETTLE   = 100;
    localparam int CYCLE_LIMIT  = 10000000;

    typedef struct {
        logic [PROTO_W-1:0] proto;
        logic [FLOW_W-1:0]  flow_id;
        logic [IP_W-1:0]    src_ip;
        logic [IP_W-1:0]    dst_ip;
        logic [MAC_W-1:0]   src_mac;
    } flow_key_t;

    typedef struct {
        t_status            status;
        logic [SLOT_W-1:0]  slot_index;
        logic [DIST_W-1:0]  probe_distance;
        logic               arp_request;
    } verdict_t;

    class rule_table_scoreboard;
        bit              occupied [TABLE_DEPTH];
        logic [IP_W-1:0] rule_src [TABLE_DEPTH];
        logic [IP_W-1:0] rule_dst [TABLE_DEPTH];
        verdict_t        pending_verdicts [$];
        int              errors;

        function int home_of(logic [FLOW_W-1:0] flow, logic [IP_W-1:0] sip);
            logic [IP_W-1:0]   quot;
            logic [FLOW_W-1:0] sum;
            quot = sip / HASH_DIVISOR;
            sum  = flow + quot[FLOW_W-1:0];
            return int'({sum[7:0], sum[15:8]}) % TABLE_DEPTH;
        endfunction

        // Probes the table the way the block does and queues the outcome.
        function void note_key(flow_key_t k);
            verdict_t v;
            int       home;
            int       slot;
            bit       done;
            home             = home_of(k.flow_id, k.src_ip);
            v.status         = ST_FULL;
            v.slot_index     = SLOT_W'(home);
            v.probe_distance = DIST_W'(TABLE_DEPTH);
            v.arp_request    = 1'b0;
            done             = 1'b0;
            for (int d = 0; d < TABLE_DEPTH && !done; d++) begin
                slot = (home + d) % TABLE_DEPTH;
                if (occupied[slot]) begin
                    if (rule_src[slot] == k.src_ip && rule_dst[slot] == k.dst_ip) begin
                        v.status         = ST_EXIST;
                        v.slot_index     = SLOT_W'(slot);
                        v.probe_distance = DIST_W'(d);
                        done             = 1'b1;
                    end
                end else begin
                    occupied[slot]   = 1'b1;
                    rule_src[slot]   = k.src_ip;
                    rule_dst[slot]   = k.dst_ip;
                    v.status         = ST_NEW;
                    v.slot_index     = SLOT_W'(slot);
                    v.probe_distance = DIST_W'(d);
                    v.arp_request    = (k.proto == PROTO_ICMP || k.proto == PROTO_UDP);
                    done             = 1'b1;
                end
            end
            pending_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic [STATUS_W-1:0] status, logic [M_DATA_W-1:0] data);
            verdict_t want;
            if (pending_verdicts.size() == 0) begin
                $error("result transfer with status %0d, slot %0d arrived with no lookup pending",
                       status, data[SLOT_LSB +: SLOT_W]);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (data[SLOT_LSB +: SLOT_W] !== want.slot_index) begin
                $error("slot_index: expected %0d, got %0d", want.slot_index,
                       data[SLOT_LSB +: SLOT_W]);
                errors++;
            end
            if (data[DIST_LSB +: DIST_W] !== want.probe_distance) begin
                $error("probe_distance: expected %0d, got %0d", want.probe_distance,
                       data[DIST_LSB +: DIST_W]);
                errors++;
            end
            if (data[ARP_BIT] !== want.arp_request) begin
                $error("arp_request: expected %0d, got %0d", want.arp_request, data[ARP_BIT]);
                errors++;
            end
            if (data[M_DATA_W-1:ARP_BIT+1] !== '0) begin
                $error("tdata padding: expected 0, got %0h", data[M_DATA_W-1:ARP_BIT+1]);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [PROTO_W-1:0]    s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    rule_table_scoreboard board;
    flow_key_t            key_log [$];
    bit                   sender_calm;
    bit                   sink_calm;
    int                   cycle_count = 0;

    nat_flow_table_linear_probe dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("nat_flow_table_linear_probe verification failed");
            $finish;
        end
    end

    // Picks a flow id so that the key hashes to the given slot.
    function automatic logic [FLOW_W-1:0] flow_for_home(int slot, logic [IP_W-1:0] sip);
        logic [FLOW_W-1:0] want;
        logic [IP_W-1:0]   quot;
        want = FLOW_W'((slot % TABLE_DEPTH)
                       + TABLE_DEPTH * $urandom_range(0, (65536 / TABLE_DEPTH) - 1));
        quot = sip / HASH_DIVISOR;
        return {want[7:0], want[15:8]} - quot[FLOW_W-1:0];
    endfunction

    function automatic flow_key_t rand_key();
        flow_key_t k;
        k.proto   = PROTO_W'($urandom_range(0, 3));
        k.flow_id = FLOW_W'($urandom);
        k.src_ip  = $urandom;
        k.dst_ip  = $urandom;
        k.src_mac = MAC_W'({$urandom, $urandom});
        return k;
    endfunction

    task automatic send_key(input flow_key_t k);
        int gap;
        if ($urandom_range(0, 31) == 0) sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k.proto;
        s_tdata  <= {k.src_mac, k.dst_ip, k.src_ip, k.flow_id};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        board.note_key(k);
        key_log.push_back(k);
    endtask

    // Holds the sender off until every outstanding lookup has returned.
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls before each transfer, checked at the rising edge.
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
            gap = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge i_clk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (m_tvalid !== 1'b1);
            board.check_verdict(m_tuser, m_tdata);
        end
    end

    initial begin
        flow_key_t k;
        int        hot_spots [4];
        int        pick;
        board    = new();
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, collisions, wrap-around and repeated rules.
        k = '{PROTO_ICMP, '0, '0, '0, '0};
        send_key(k);
        send_key('{2'd3, '1, '1, '1, '1});
        send_key(k);
        k = rand_key();
        k.proto   = PROTO_UDP;
        k.flow_id = flow_for_home(0, k.src_ip);
        send_key(k);
        k = rand_key();
        k.proto   = 2'd2;
        k.flow_id = flow_for_home(0, k.src_ip);
        send_key(k);
        send_key(key_log[3]);
        k = rand_key();
        k.proto   = 2'd2;
        k.flow_id = flow_for_home(TABLE_DEPTH - 1, k.src_ip);
        send_key(k);
        // A second key homed on the last slot has to wrap past the cluster at slot 0.
        k = rand_key();
        k.proto   = PROTO_ICMP;
        k.flow_id = flow_for_home(TABLE_DEPTH - 1, k.src_ip);
        send_key(k);
        send_key(k);
        k         = key_log[4];
        k.flow_id = k.flow_id + 16'h0100;
        send_key(k);
        k = rand_key();
        k.proto = 2'd3;
        send_key(k);
        k       = key_log[0];
        k.proto = PROTO_UDP;
        send_key(k);
        send_key('{2'd2, '0, '1, '0, '1});
        send_key('{PROTO_UDP, '1, 32'd10000, 32'h0000_ffff, 48'h0000_ffff_0000});
        drain();

        // Random: repeated rules, reused address pairs and dense clusters.
        foreach (hot_spots[i]) hot_spots[i] = $urandom_range(0, TABLE_DEPTH - 1);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                k       = key_log[$urandom_range(0, key_log.size() - 1)];
                k.proto = PROTO_W'($urandom_range(0, 3));
            end else if (pick < 40) begin
                k         = key_log[$urandom_range(0, key_log.size() - 1)];
                k.flow_id = FLOW_W'($urandom);
                k.src_mac = MAC_W'({$urandom, $urandom});
            end else if (pick < 80) begin
                k         = rand_key();
                k.flow_id = flow_for_home(hot_spots[$urandom_range(0, 3)]
                                          + $urandom_range(0, 31), k.src_ip);
            end else begin
                k = rand_key();
            end
            send_key(k);
            if ($urandom_range(0, 99) == 0) drain();
        end

        drain();
        repeat (END_SETTLE) @(posedge i_clk);
        if (board.errors == 0 && board.pending_verdicts.size() == 0) begin
            $display("nat_flow_table_linear_probe verification clean");
        end else begin
            $display("nat_flow_table_linear_probe verification failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/nft_pkg.sv
rtl/core/nft_ram.sv
rtl/core/nft_front.sv
rtl/core/nft_queue.sv
rtl/core/nft_back.sv
rtl/core/nat_flow_table_linear_probe.sv
rtl/core/nft_checker.sv
tb/testbench.sv
